// File: rtl/twister_rng_with_lcg_seeding_macros.svh
// Assertion macros shared by the RNG block.
`ifndef TWISTER_RNG_WITH_LCG_SEEDING_MACROS_SVH
`define TWISTER_RNG_WITH_LCG_SEEDING_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge out of reset.
`define TWRNG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("twrng assertion failed");
// Next-cycle implication.
`define TWRNG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("twrng assertion failed");
`else
`define TWRNG_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TWRNG_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/twrng_pkg.sv
package twrng_pkg;

    localparam int STORE_WORDS  = 624;
    localparam int TWIST_OFFSET = 379;
    localparam int ADDR_W       = $clog2(STORE_WORDS);
    localparam int OFFSET_MOD   = TWIST_OFFSET % STORE_WORDS;

    localparam logic [31:0] LCG_MUL    = 32'd2147001325;
    localparam logic [31:0] LCG_ADD    = 32'd715136305;
    localparam logic [31:0] SEED_XOR   = 32'h31415926;
    localparam logic [31:0] UPPER_BIT  = 32'h80000000;
    localparam logic [31:0] LOWER_BITS = 32'h7FFFFFFF;
    localparam logic [31:0] TWIST_XOR  = 32'h9908B0DF;
    localparam logic [31:0] TEMPER_B   = 32'h9D2C5680;
    localparam logic [31:0] TEMPER_C   = 32'hEFC60000;

    localparam logic OP_RESEED = 1'b0;
    localparam logic OP_DRAW   = 1'b1;

    localparam logic STATUS_OK         = 1'b0;
    localparam logic STATUS_NOT_SEEDED = 1'b1;

    function automatic logic [31:0] twist_word(input logic [31:0] here_w,
                                               input logic [31:0] next_w,
                                               input logic [31:0] far_w);
        logic [31:0] mix;
        mix = (here_w & UPPER_BIT) | (next_w & LOWER_BITS);
        return far_w ^ (mix >> 1) ^ (mix[0] ? TWIST_XOR : 32'd0);
    endfunction

    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] r;
        r = w;
        r = r ^ (r >> 11);
        r = r ^ ((r << 7) & TEMPER_B);
        r = r ^ ((r << 15) & TEMPER_C);
        r = r ^ (r >> 18);
        return r;
    endfunction

endpackage

// File: rtl/twrng_lcg.sv
module twrng_lcg (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  logic [31:0] seed,
    input  logic        step,
    output logic [31:0] word
);

    logic [31:0] lcg_reg;
    logic [31:0] lcg_next;

    assign lcg_next = lcg_reg * twrng_pkg::LCG_MUL + twrng_pkg::LCG_ADD;
    // Each fill word is the advanced state, halves swapped, whitened.
    assign word = twrng_pkg::SEED_XOR ^ {lcg_next[15:0], lcg_next[31:16]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lcg_reg <= 32'd0;
        end else if (load) begin
            lcg_reg <= seed;
        end else if (step) begin
            lcg_reg <= lcg_next;
        end
    end

endmodule

// File: rtl/twrng_rem.sv
module twrng_rem (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] remainder
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [31:0] dvd_reg;
    logic [31:0] div_reg;
    logic [32:0] trial;
    logic [31:0] rem_next;

    // Restoring remainder, one dividend bit per cycle from the top.
    always_comb begin
        trial = {rem_reg, dvd_reg[31]};
        if (trial >= {1'b0, div_reg}) begin
            rem_next = 32'(trial - {1'b0, div_reg});
        end else begin
            rem_next = trial[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= 32'd0;
            dvd_reg <= dividend;
            div_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[30:0], 1'b0};
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/twister_rng_with_lcg_seeding.sv
// Reseed: the store is filled one word per cycle after the transfer.
// Draw: store reads in RD_HERE, RD_NEXT and RD_FAR, write back in TWIST, then a bit-serial remainder;
// a span that wraps to zero skips the remainder, and the result is registered in FINISH.
// A draw before any reseed goes straight from IDLE to FINISH and answers with zero values.
// One item is worked on at a time; the remainder unit sets the draw rate.
// Reset clears control, position and seed state; the word store is not cleared.
`include "twister_rng_with_lcg_seeding_macros.svh"

module twister_rng_with_lcg_seeding (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // seed[31:0], range_low[63:32], range_high[95:64]
    input  logic [0:0]  s_tuser,   // op[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // raw_word[31:0], ranged_value[63:32]
    output logic [0:0]  m_tuser    // status[0]
);

    localparam int AW = twrng_pkg::ADDR_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(twrng_pkg::STORE_WORDS - 1);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_FILL    = 3'd1;
    localparam logic [2:0] ST_RD_HERE = 3'd2;
    localparam logic [2:0] ST_RD_NEXT = 3'd3;
    localparam logic [2:0] ST_RD_FAR  = 3'd4;
    localparam logic [2:0] ST_TWIST   = 3'd5;
    localparam logic [2:0] ST_DIV     = 3'd6;
    localparam logic [2:0] ST_FINISH  = 3'd7;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] position_reg, position_next;
    logic          seeded_reg, seeded_next;
    logic [AW-1:0] fill_reg, fill_next;
    logic          m_tvalid_reg, m_tvalid_next;

    logic [31:0]   lo_reg;
    logic [31:0]   span_reg;
    logic [31:0]   here_word_reg;
    logic [31:0]   next_word_reg;
    logic [31:0]   raw_reg;
    logic [31:0]   ranged_reg;
    logic          status_reg;
    logic [63:0]   m_data_reg;
    logic          m_user_reg;

    logic [31:0]   mem [twrng_pkg::STORE_WORDS];
    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_data_reg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;

    logic          in_xfer;
    logic          out_free;
    logic [AW-1:0] next_addr;
    logic [AW:0]   far_sum;
    logic [AW-1:0] far_addr;
    logic [31:0]   twisted;
    logic [31:0]   tempered;

    logic          lcg_load;
    logic          lcg_step;
    logic [31:0]   lcg_word;
    logic          rem_start;
    logic          rem_done;
    logic [31:0]   rem_value;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign next_addr = (position_reg == LAST_ADDR) ? '0 : position_reg + AW'(1);
    assign far_sum   = {1'b0, position_reg} + (AW+1)'(twrng_pkg::OFFSET_MOD);
    assign far_addr  = (far_sum >= (AW+1)'(twrng_pkg::STORE_WORDS))
                     ? AW'(far_sum - (AW+1)'(twrng_pkg::STORE_WORDS))
                     : far_sum[AW-1:0];

    assign twisted  = twrng_pkg::twist_word(here_word_reg, next_word_reg, rd_data_reg);
    assign tempered = twrng_pkg::temper(twisted);

    assign lcg_load  = in_xfer && (s_tuser[0] == twrng_pkg::OP_RESEED);
    assign lcg_step  = (state_reg == ST_FILL);
    assign rem_start = (state_reg == ST_TWIST) && (span_reg != 32'd0);

    twrng_lcg u_lcg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (lcg_load),
        .seed    (s_tdata[31:0]),
        .step    (lcg_step),
        .word    (lcg_word)
    );

    twrng_rem u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (rem_start),
        .dividend  (tempered),
        .divisor   (span_reg),
        .done      (rem_done),
        .remainder (rem_value)
    );

    // Read address follows the draw sequence; write port serves fill and write back.
    always_comb begin
        unique case (state_reg)
            ST_RD_NEXT: rd_addr = next_addr;
            ST_RD_FAR:  rd_addr = far_addr;
            default:    rd_addr = position_reg;
        endcase
        wr_en   = (state_reg == ST_FILL) || (state_reg == ST_TWIST);
        wr_addr = (state_reg == ST_FILL) ? fill_reg : position_reg;
        wr_data = (state_reg == ST_FILL) ? lcg_word : twisted;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb begin
        state_next    = state_reg;
        position_next = position_reg;
        seeded_next   = seeded_reg;
        fill_next     = fill_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (s_tuser[0] == twrng_pkg::OP_RESEED) begin
                        state_next = ST_FILL;
                        fill_next  = '0;
                    end else if (seeded_reg) begin
                        state_next = ST_RD_HERE;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FILL: begin
                fill_next = fill_reg + AW'(1);
                if (fill_reg == LAST_ADDR) begin
                    state_next    = ST_IDLE;
                    position_next = '0;
                    seeded_next   = 1'b1;
                end
            end
            ST_RD_HERE: state_next = ST_RD_NEXT;
            ST_RD_NEXT: state_next = ST_RD_FAR;
            ST_RD_FAR:  state_next = ST_TWIST;
            ST_TWIST: begin
                position_next = next_addr;
                state_next    = (span_reg != 32'd0) ? ST_DIV : ST_FINISH;
            end
            ST_DIV: begin
                if (rem_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            position_reg <= '0;
            seeded_reg   <= 1'b0;
            fill_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            position_reg <= position_next;
            seeded_reg   <= seeded_next;
            fill_reg     <= fill_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            lo_reg     <= s_tdata[63:32];
            span_reg   <= s_tdata[95:64] - s_tdata[63:32] + 32'd1;
            raw_reg    <= 32'd0;
            ranged_reg <= 32'd0;
            status_reg <= seeded_reg ? twrng_pkg::STATUS_OK : twrng_pkg::STATUS_NOT_SEEDED;
        end
        if (state_reg == ST_RD_NEXT) begin
            here_word_reg <= rd_data_reg;
        end
        if (state_reg == ST_RD_FAR) begin
            next_word_reg <= rd_data_reg;
        end
        if (state_reg == ST_TWIST) begin
            raw_reg    <= tempered;
            ranged_reg <= lo_reg + tempered;
        end
        if ((state_reg == ST_DIV) && rem_done) begin
            ranged_reg <= lo_reg + rem_value;
        end
        if ((state_reg == ST_FINISH) && out_free) begin
            m_data_reg <= {ranged_reg, raw_reg};
            m_user_reg <= status_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;

    // A not-seeded result carries zero values.
    `TWRNG_ASSERT_IMP(a_not_seeded_zero, aclk, aresetn,
        m_tvalid && (m_tuser[0] == twrng_pkg::STATUS_NOT_SEEDED), m_tdata == 64'd0)
    // The draw position never leaves the store.
    `TWRNG_ASSERT_IMP(a_position_range, aclk, aresetn,
        1'b1, {1'b0, position_reg} < (AW+1)'(twrng_pkg::STORE_WORDS))
    // In the cycle after an input transfer the block is busy.
    `TWRNG_ASSERT_NXT(a_busy_after_xfer, aclk, aresetn,
        s_tvalid && s_tready, !s_tready)

endmodule

// File: test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_ITEMS  = 1430;
    localparam int NO_RESEED_RUN = 700;
    localparam int MAX_REPORTS   = 40;

    localparam logic DRAW   = twrng_pkg::OP_DRAW;
    localparam logic RESEED = twrng_pkg::OP_RESEED;

    typedef struct packed {
        logic [31:0] raw_word;
        logic [31:0] ranged_value;
        logic        status;
    } draw_result_t;

    typedef struct {
        logic         op;
        logic [31:0]  seed;
        logic [31:0]  range_low;
        logic [31:0]  range_high;
        bit           fixed;
        draw_result_t result;
    } stim_row_t;

    typedef enum int {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PATTERN,
        READY_SPARSE
    } ready_mode_t;

    localparam draw_result_t UNSEEDED_RESULT = '{32'd0, 32'd0, twrng_pkg::STATUS_NOT_SEEDED};
    localparam draw_result_t FROM_PREDICTOR  = '{32'd0, 32'd0, twrng_pkg::STATUS_OK};

    localparam logic [31:0] INT_MIN = 32'h8000_0000;
    localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;   // seed[31:0], range_low[63:32], range_high[95:64]
    logic [0:0]  s_tuser;   // op[0]
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // raw_word[31:0], ranged_value[63:32]
    logic [0:0]  m_tuser;   // status[0]

    twister_rng_with_lcg_seeding dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Generator state as the block should hold it.
    logic [31:0] mt_words [twrng_pkg::STORE_WORDS];
    int unsigned mt_pos;
    logic [31:0] lcg_state;
    bit          is_seeded;

    draw_result_t draws_due [$];
    int unsigned  failures;
    int unsigned  burst_left;
    int unsigned  cycle_count;

    // Rows whose result is known by inspection carry it; the others take the predictor's.
    stim_row_t directed_rows [21] = '{
        '{DRAW,   32'h0000_0000, 32'd0,        32'd0,        1'b1, UNSEEDED_RESULT},
        '{DRAW,   32'h0000_0000, INT_MIN,      INT_MAX,      1'b1, UNSEEDED_RESULT},
        '{DRAW,   32'hFFFF_FFFF, INT_MAX,      INT_MIN,      1'b1, UNSEEDED_RESULT},
        '{RESEED, 32'h0000_0000, 32'd0,        32'd0,        1'b0, FROM_PREDICTOR},
        '{DRAW,   32'h0000_0000, 32'd0,        32'hFFFF_FFFF, 1'b0, FROM_PREDICTOR},
        '{DRAW,   32'hFFFF_FFFF, INT_MIN,      INT_MAX,      1'b0, FROM_PREDICTOR},
        '{DRAW,   32'h0000_0000, INT_MAX,      INT_MAX,      1'b0, FROM_PREDICTOR},
        '{DRAW,   32'h0000_0000, INT_MIN,      INT_MIN,      1'b0, FROM_PREDICTOR},
        '{DRAW,   32'h0000_0000, 32'd10,       32'd3,        1'b0, FROM_PREDICTOR},
        '{DRAW,   32'h0000_0000, INT_MAX,      INT_MIN,      1'b0, FROM_PREDICTOR},
        '{DRAW,   32'h0000_0000, -32'sd5,      32'd5,        1'b0, FROM_PREDICTOR},
        '{DRAW,   32'h0000_0000, 32'd0,        INT_MAX,      1'b0, FROM_PREDICTOR},
        '{RESEED, 32'hFFFF_FFFF, INT_MIN,      INT_MAX,      1'b0, FROM_PREDICTOR},
        '{DRAW,   32'h0000_0000, 32'd0,        32'd1,        1'b0, FROM_PREDICTOR},
        '{DRAW,   32'h0000_0000, 32'hFFFF_FFFF, 32'd0,       1'b0, FROM_PREDICTOR},
        '{RESEED, 32'h8000_0000, 32'd0,        32'd0,        1'b0, FROM_PREDICTOR},
        '{DRAW,   32'h0000_0000, 32'd1000,     32'd1999,     1'b0, FROM_PREDICTOR},
        '{RESEED, 32'h0000_0001, 32'd0,        32'd0,        1'b0, FROM_PREDICTOR},
        '{RESEED, 32'h1234_5678, 32'd0,        32'd0,        1'b0, FROM_PREDICTOR},
        '{DRAW,   32'h0000_0000, 32'd0,        32'd6,        1'b0, FROM_PREDICTOR},
        '{DRAW,   32'h0000_0000, 32'h7FFF_FFF0, 32'h8000_000F, 1'b0, FROM_PREDICTOR}
    };

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic logic [31:0] temper_word(input logic [31:0] w);
        logic [31:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & twrng_pkg::TEMPER_B);
        y = y ^ ((y << 15) & twrng_pkg::TEMPER_C);
        return y ^ (y >> 18);
    endfunction

    // Advances the generator by one item; a draw yields a result, a reseed none.
    task automatic step_generator(input logic op, input logic [31:0] seed,
                                  input logic [31:0] lo, input logic [31:0] hi,
                                  output bit has_result, output draw_result_t res);
        int unsigned here;
        int unsigned next;
        int unsigned far;
        logic [31:0] mix;
        logic [31:0] twisted;
        logic [31:0] span;
        has_result = 1'b0;
        res = FROM_PREDICTOR;
        if (op == twrng_pkg::OP_RESEED) begin
            lcg_state = seed;
            for (int i = 0; i < twrng_pkg::STORE_WORDS; i++) begin
                lcg_state = lcg_state * twrng_pkg::LCG_MUL + twrng_pkg::LCG_ADD;
                mt_words[i] = twrng_pkg::SEED_XOR ^ {lcg_state[15:0], lcg_state[31:16]};
            end
            mt_pos = 0;
            is_seeded = 1'b1;
        end else if (!is_seeded) begin
            has_result = 1'b1;
            res = UNSEEDED_RESULT;
        end else begin
            here = mt_pos;
            next = (here + 1 >= twrng_pkg::STORE_WORDS) ? 0 : here + 1;
            far = (here + twrng_pkg::TWIST_OFFSET) % twrng_pkg::STORE_WORDS;
            mix = (mt_words[here] & twrng_pkg::UPPER_BIT)
                | (mt_words[next] & twrng_pkg::LOWER_BITS);
            twisted = mt_words[far] ^ (mix >> 1)
                    ^ (mix[0] ? twrng_pkg::TWIST_XOR : 32'd0);
            mt_words[here] = twisted;
            mt_pos = next;
            res.raw_word = temper_word(twisted);
            span = hi - lo + 32'd1;
            res.ranged_value = (span == 32'd0) ? lo + res.raw_word
                                               : lo + res.raw_word % span;
            res.status = twrng_pkg::STATUS_OK;
            has_result = 1'b1;
        end
    endtask

    task automatic report_failure(input string msg);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    task automatic send_item(input logic op, input logic [31:0] seed,
                             input logic [31:0] lo, input logic [31:0] hi,
                             input bit fixed, input draw_result_t fixed_res);
        bit           has_result;
        draw_result_t res;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {hi, lo, seed};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        step_generator(op, seed, lo, hi, has_result, res);
        if (has_result)
            draws_due.push_back(fixed ? fixed_res : res);
    endtask

    // Bursts of back-to-back transfers separated by gaps of random length.
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 45) : $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(0, 40);
        end
    endtask

    initial begin
        ready_mode_t mode;
        int unsigned hold;
        logic [7:0]  pattern;
        m_tready = 1'b0;
        mode = READY_ALWAYS;
        hold = 0;
        pattern = 8'b1011_0010;
        forever begin
            @(posedge aclk);
            if (hold == 0) begin
                mode = ready_mode_t'($urandom_range(0, 3));
                hold = $urandom_range(20, 400);
            end else begin
                hold--;
            end
            pattern = {pattern[6:0], pattern[7]};
            case (mode)
                READY_ALWAYS:  m_tready <= 1'b1;
                READY_RANDOM:  m_tready <= 1'($urandom_range(0, 1));
                READY_PATTERN: m_tready <= pattern[0];
                default:       m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        draw_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (draws_due.size() == 0) begin
                report_failure($sformatf("result transfer with none expected: raw %h ranged %h",
                                         m_tdata[31:0], m_tdata[63:32]));
            end else begin
                want = draws_due.pop_front();
                if (m_tdata[31:0] !== want.raw_word)
                    report_failure($sformatf("raw_word %h, expected %h",
                                             m_tdata[31:0], want.raw_word));
                if (m_tdata[63:32] !== want.ranged_value)
                    report_failure($sformatf("ranged_value %h, expected %h",
                                             m_tdata[63:32], want.ranged_value));
                if (m_tuser[0] !== want.status)
                    report_failure($sformatf("status %b, expected %b",
                                             m_tuser[0], want.status));
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        logic        op;
        logic [31:0] seed;
        logic [31:0] lo;
        logic [31:0] hi;
        failures = 0;
        burst_left = 0;
        mt_pos = 0;
        lcg_state = 32'd0;
        is_seeded = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[r]) begin
            send_item(directed_rows[r].op, directed_rows[r].seed,
                      directed_rows[r].range_low, directed_rows[r].range_high,
                      directed_rows[r].fixed, directed_rows[r].result);
            pace_sender();
        end

        // A long run of draws after the first reseed walks the position past the
        // end of the store, so both the next and the offset index wrap around.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 0)
                op = twrng_pkg::OP_RESEED;
            else if (i > NO_RESEED_RUN && $urandom_range(0, 249) == 0)
                op = twrng_pkg::OP_RESEED;
            else
                op = twrng_pkg::OP_DRAW;
            seed = $urandom;
            lo = $urandom;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: hi = lo + $urandom_range(0, 20);
                4, 5:       hi = $urandom;
                6:          hi = lo - 32'd1;
                7:          hi = lo - $urandom_range(2, 1000);
                8:          hi = lo;
                default:    hi = lo + (32'd1 << $urandom_range(0, 31)) - 32'd1;
            endcase
            send_item(op, seed, lo, hi, 1'b0, FROM_PREDICTOR);
            pace_sender();
        end
        s_tvalid <= 1'b0;

        while (draws_due.size() != 0) @(posedge aclk);
        // A trailing reseed may still be filling the store.
        repeat (twrng_pkg::STORE_WORDS + 64) @(posedge aclk);
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
